>>> hdl/drl_pkg.sv
// ----------------------------------------------------------------------------
// drl_pkg
// Shared types, constants and helpers for the dirty rectangle list.
// ----------------------------------------------------------------------------
package drl_pkg;

  // list geometry
  localparam int MAX_RECTS    = 16;
  localparam int CNT_W        = $clog2(MAX_RECTS + 1);
  localparam int IDX_W        = $clog2(MAX_RECTS);

  // field widths
  localparam int POS_W        = 16;
  localparam int EXT_W        = POS_W + 1;
  localparam int DIM_W        = 15;
  localparam int COORD_W      = 12;
  localparam int SIZE_W       = 13;
  localparam int CFG_W        = 13;
  localparam int SCREEN_LIMIT = 4096;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_FLUSH = 2'd1,
    MODE_FULL  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_DROPPED  = 3'd0,
    ST_COVERED  = 3'd1,
    ST_REPLACED = 3'd2,
    ST_APPENDED = 3'd3,
    ST_FLUSHED  = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [POS_W-1:0]  rect_left;
    logic signed [POS_W-1:0]  rect_top;
    logic [DIM_W-1:0]         rect_width;
    logic [DIM_W-1:0]         rect_height;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
    logic [SIZE_W-1:0]    out_w;
    logic [SIZE_W-1:0]    out_h;
    logic                 last;
  } rsp_t;

  // one stored rectangle
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } rect_t;

  localparam rect_t RECT_ZERO = '0;

  // true when rectangle a lies within rectangle b
  function automatic logic rect_inside(rect_t a, rect_t b);
    logic [SIZE_W:0] a_r, a_b, b_r, b_b;
    a_r = {2'b00, a.x} + {1'b0, a.w};
    a_b = {2'b00, a.y} + {1'b0, a.h};
    b_r = {2'b00, b.x} + {1'b0, b.w};
    b_b = {2'b00, b.y} + {1'b0, b.h};
    return (a.x >= b.x) && (a_r <= b_r) && (a.y >= b.y) && (a_b <= b_b);
  endfunction

  function automatic rsp_t make_rsp(status_t s, rect_t r, logic last);
    rsp_t o;
    o.status = s;
    o.out_x  = r.x;
    o.out_y  = r.y;
    o.out_w  = r.w;
    o.out_h  = r.h;
    o.last   = last;
    return o;
  endfunction

endpackage

>>> hdl/drl_table.sv
// ----------------------------------------------------------------------------
// drl_table
// Rectangle store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module drl_table import drl_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rect_t            wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output rect_t            rd_data
);

  rect_t mem [MAX_RECTS];

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/drl_clip.sv
// ----------------------------------------------------------------------------
// drl_clip
// Screen clamp, off-screen and full-list test, and clip of an add request.
// ----------------------------------------------------------------------------
module drl_clip import drl_pkg::*; (
  input  req_t             item,
  input  logic [CFG_W-1:0] screen_width,
  input  logic [CFG_W-1:0] screen_height,
  input  logic [CNT_W-1:0] count,
  output logic             drop,
  output rect_t            box,
  output rect_t            screen
);

  logic [SIZE_W-1:0]       sw, sh;
  logic signed [EXT_W-1:0] l, t, r, b, sw_s, sh_s;
  logic [COORD_W-1:0]      x0, y0;
  logic [SIZE_W-1:0]       x1, y1;

  // screen size saturates at the limit
  assign sw = (screen_width > SIZE_W'(SCREEN_LIMIT)) ? SIZE_W'(SCREEN_LIMIT)
                                                     : screen_width;
  assign sh = (screen_height > SIZE_W'(SCREEN_LIMIT)) ? SIZE_W'(SCREEN_LIMIT)
                                                      : screen_height;
  assign sw_s = $signed({{(EXT_W-SIZE_W){1'b0}}, sw});
  assign sh_s = $signed({{(EXT_W-SIZE_W){1'b0}}, sh});

  // edges, one bit wider than the inputs
  assign l = {item.rect_left[POS_W-1], item.rect_left};
  assign t = {item.rect_top[POS_W-1], item.rect_top};
  assign r = l + $signed({{(EXT_W-DIM_W){1'b0}}, item.rect_width});
  assign b = t + $signed({{(EXT_W-DIM_W){1'b0}}, item.rect_height});

  // list full or rectangle entirely off screen
  assign drop = (count >= CNT_W'(MAX_RECTS)) || (l >= sw_s) || (t >= sh_s) ||
                r[EXT_W-1] || b[EXT_W-1];

  // intersection with the screen
  assign x0 = l[EXT_W-1] ? '0 : l[COORD_W-1:0];
  assign y0 = t[EXT_W-1] ? '0 : t[COORD_W-1:0];
  assign x1 = (r > sw_s) ? sw : r[SIZE_W-1:0];
  assign y1 = (b > sh_s) ? sh : b[SIZE_W-1:0];

  assign box.x = x0;
  assign box.y = y0;
  assign box.w = x1 - {1'b0, x0};
  assign box.h = y1 - {1'b0, y0};

  // whole-screen rectangle for a list reset
  assign screen.x = '0;
  assign screen.y = '0;
  assign screen.w = sw;
  assign screen.h = sh;

endmodule

>>> hdl/dirty_rect_list.sv
// ----------------------------------------------------------------------------
// dirty_rect_list
// Bounded list of damaged screen rectangles with add, flush and full reset.
// ----------------------------------------------------------------------------
//  channel  | signals                     | role
//  ---------+-----------------------------+------------------------------------
//  req      | req_valid, req_ready, req   | add / flush / whole-screen command
//  rsp      | rsp_valid, rsp_ready, rsp   | result rectangles with last flag
//  cfg      | cfg_we, cfg_index, cfg_data | screen width and height writes
//
//  one command at a time; req_ready is high only while the controller waits
//  add: clip, then a pipelined walk of the store at one entry per cycle,
//  ending in an append, in a cover or a replace on a match, or in a drop
//  flush: entries read out in turn while rsp is free; whole-screen, empty flush
//  and unused mode give a single result; a registered result stage lets a new
//  command in while rsp is stalled; reset clears the count, the screen size,
//  the compare flag and the handshake state only
module dirty_rect_list import drl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLIP   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FOUT   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [CFG_W-1:0]   screen_width, screen_height;
  req_t               item;
  logic [CNT_W-1:0]   count, count_next;
  rect_t              box, box_next;
  rsp_t               res, res_next;
  logic [CNT_W-1:0]   issue_idx, issue_next;
  logic               cmp_vld, cmp_vld_next;
  logic [IDX_W-1:0]   cmp_idx, cmp_idx_next;
  logic [CNT_W-1:0]   flush_idx, flush_next, flush_inc;
  logic               flush_last;

  logic               out_free, out_load;
  rsp_t               out_data;

  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  rect_t              wr_data, rd_data;

  logic               clip_drop;
  rect_t              clip_box, screen_box;

  drl_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  drl_clip u_clip (
    .item          (item),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .count         (count),
    .drop          (clip_drop),
    .box           (clip_box),
    .screen        (screen_box)
  );

  assign req_ready  = (state == S_IDLE);
  assign out_free   = !rsp_valid || rsp_ready;
  assign flush_inc  = flush_idx + CNT_W'(1);
  assign flush_last = (flush_inc == count);

  // command sequencer: read, compare, write back
  always_comb begin
    state_next   = state;
    count_next   = count;
    box_next     = box;
    res_next     = res;
    issue_next   = issue_idx;
    cmp_vld_next = 1'b0;
    cmp_idx_next = cmp_idx;
    flush_next   = flush_idx;
    out_load     = 1'b0;
    out_data     = res;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = box;
    rd_en        = 1'b0;
    rd_addr      = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.mode)
            MODE_ADD: begin
              state_next = S_CLIP;
            end
            MODE_FLUSH: begin
              if (count == '0) begin
                res_next   = make_rsp(ST_EMPTY, RECT_ZERO, 1'b1);
                state_next = S_RESULT;
              end else begin
                flush_next = '0;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_FOUT;
              end
            end
            MODE_FULL: begin
              wr_en      = 1'b1;
              wr_addr    = '0;
              wr_data    = screen_box;
              count_next = CNT_W'(1);
              res_next   = make_rsp(ST_EMPTY, screen_box, 1'b1);
              state_next = S_RESULT;
            end
            MODE_NONE: begin
              res_next   = make_rsp(ST_DROPPED, RECT_ZERO, 1'b1);
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_CLIP: begin
        if (clip_drop) begin
          res_next   = make_rsp(ST_DROPPED, RECT_ZERO, 1'b1);
          state_next = S_RESULT;
        end else begin
          box_next   = clip_box;
          issue_next = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // compare the entry read last cycle while the next read goes out
        if (cmp_vld && rect_inside(box, rd_data)) begin
          res_next   = make_rsp(ST_COVERED, box, 1'b1);
          state_next = S_RESULT;
        end else if (cmp_vld && rect_inside(rd_data, box)) begin
          wr_en      = 1'b1;
          wr_addr    = cmp_idx;
          res_next   = make_rsp(ST_REPLACED, box, 1'b1);
          state_next = S_RESULT;
        end else if (issue_idx < count) begin
          rd_en        = 1'b1;
          rd_addr      = issue_idx[IDX_W-1:0];
          issue_next   = issue_idx + CNT_W'(1);
          cmp_vld_next = 1'b1;
          cmp_idx_next = issue_idx[IDX_W-1:0];
        end else if (!cmp_vld) begin
          wr_en      = 1'b1;
          wr_addr    = count[IDX_W-1:0];
          count_next = count + CNT_W'(1);
          res_next   = make_rsp(ST_APPENDED, box, 1'b1);
          state_next = S_RESULT;
        end
      end
      S_FOUT: begin
        // emit one entry and fetch the following one in the same cycle
        if (out_free) begin
          out_load = 1'b1;
          out_data = make_rsp(ST_FLUSHED, rd_data, flush_last);
          if (flush_last) begin
            count_next = '0;
            state_next = S_IDLE;
          end else begin
            flush_next = flush_inc;
            rd_en      = 1'b1;
            rd_addr    = flush_inc[IDX_W-1:0];
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data   = res;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      cmp_vld       <= 1'b0;
      rsp_valid     <= 1'b0;
      screen_width  <= '0;
      screen_height <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cmp_vld <= cmp_vld_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    box       <= box_next;
    res       <= res_next;
    issue_idx <= issue_next;
    cmp_idx   <= cmp_idx_next;
    flush_idx <= flush_next;
    if (out_load) begin
      rsp <= out_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RECTS))
    else $error("rectangle count above list depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !out_load)
    else $error("stalled result overwritten");

  a_last_only_flush: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (rsp.status == ST_FLUSHED))
    else $error("non-final result outside a flush");

  a_cmp_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cmp_vld) |-> (CNT_W'(cmp_idx) < count))
    else $error("compare of an entry beyond the list");
`endif

endmodule

>>> dv/tb_dirty_rect_list.sv
// ----------------------------------------------------------------------------
// tb_dirty_rect_list
// Self-checking bench for the dirty rectangle list. A scoreboard class keeps
// its own copy of the screen size and the rectangle list, predicts every
// result of each accepted command and compares the result stream field by
// field. Stimulus is a directed opening followed by random phases at several
// screen sizes, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_dirty_rect_list import drl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 29;
  localparam int IDLE_PCT      = 9;

  // scoreboard: shadow list, expected result queue and checker
  class damage_scoreboard;
    typedef struct packed {
      int x;
      int y;
      int w;
      int h;
    } box_t;

    int   scr_w = 0;
    int   scr_h = 0;
    box_t boxes[MAX_RECTS];
    int   box_cnt = 0;
    rsp_t pending_rsp[$];
    int   mismatches = 0;
    int   results_seen = 0;

    function void set_screen(int w, int h);
      w = w & 16'h1FFF;
      h = h & 16'h1FFF;
      scr_w = (w > SCREEN_LIMIT) ? SCREEN_LIMIT : w;
      scr_h = (h > SCREEN_LIMIT) ? SCREEN_LIMIT : h;
    endfunction

    function int outstanding();
      return pending_rsp.size();
    endfunction

    // append one expected result to the tail of the queue
    function void queue_rsp(rsp_t r);
      pending_rsp = {pending_rsp, r};
    endfunction

    // true when inner lies within outer
    function bit covers(box_t outer, box_t inner);
      return inner.x >= outer.x && inner.x + inner.w <= outer.x + outer.w &&
             inner.y >= outer.y && inner.y + inner.h <= outer.y + outer.h;
    endfunction

    function rsp_t pack_rsp(status_t st, box_t b, logic fin);
      rsp_t o;
      o.status = st;
      o.out_x  = b.x[COORD_W-1:0];
      o.out_y  = b.y[COORD_W-1:0];
      o.out_w  = b.w[SIZE_W-1:0];
      o.out_h  = b.h[SIZE_W-1:0];
      o.last   = fin;
      return o;
    endfunction

    // clip against the screen, then fold into the list
    function status_t merge_damage(req_t item, output box_t clip);
      int l, t, r, b, wd, ht;
      clip = '0;
      l  = {{16{item.rect_left[POS_W-1]}}, item.rect_left};
      t  = {{16{item.rect_top[POS_W-1]}}, item.rect_top};
      wd = item.rect_width;
      ht = item.rect_height;
      r  = l + wd;
      b  = t + ht;
      if (box_cnt >= MAX_RECTS || l >= scr_w || t >= scr_h || r < 0 || b < 0)
        return ST_DROPPED;
      clip.x = (l < 0) ? 0 : l;
      clip.y = (t < 0) ? 0 : t;
      clip.w = ((r > scr_w) ? scr_w : r) - clip.x;
      clip.h = ((b > scr_h) ? scr_h : b) - clip.y;
      for (int i = 0; i < box_cnt; i++) begin
        if (covers(boxes[i], clip))
          return ST_COVERED;
        if (covers(clip, boxes[i])) begin
          boxes[i] = clip;
          return ST_REPLACED;
        end
      end
      boxes[box_cnt] = clip;
      box_cnt++;
      return ST_APPENDED;
    endfunction

    // predict the results of one accepted request transaction
    task note_request(req_t item);
      box_t    clip;
      status_t st;
      case (item.mode)
        MODE_ADD: begin
          st = merge_damage(item, clip);
          if (st == ST_DROPPED)
            clip = '0;
          queue_rsp(pack_rsp(st, clip, 1'b1));
        end
        MODE_FLUSH: begin
          if (box_cnt == 0)
            queue_rsp(pack_rsp(ST_EMPTY, '0, 1'b1));
          for (int i = 0; i < box_cnt; i++)
            queue_rsp(pack_rsp(ST_FLUSHED, boxes[i], i == box_cnt - 1));
          box_cnt = 0;
        end
        MODE_FULL: begin
          clip   = '0;
          clip.w = scr_w;
          clip.h = scr_h;
          boxes[0] = clip;
          box_cnt  = 1;
          queue_rsp(pack_rsp(ST_EMPTY, clip, 1'b1));
        end
        default: begin
          queue_rsp(pack_rsp(ST_DROPPED, '0, 1'b1));
        end
      endcase
    endtask

    task report(string msg);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // compare one response transaction with the oldest expectation
    task check_result(rsp_t got);
      rsp_t exp;
      results_seen++;
      if (pending_rsp.size() == 0) begin
        report($sformatf("result %0d with nothing pending (code %0d x %0d y %0d w %0d h %0d)",
                         results_seen, got.status, got.out_x, got.out_y, got.out_w,
                         got.out_h));
        return;
      end
      exp = pending_rsp.pop_front();
      if (got.status !== exp.status)
        report($sformatf("result %0d code got %0d want %0d", results_seen, got.status,
                         exp.status));
      if (got.out_x !== exp.out_x)
        report($sformatf("result %0d x got %0d want %0d", results_seen, got.out_x, exp.out_x));
      if (got.out_y !== exp.out_y)
        report($sformatf("result %0d y got %0d want %0d", results_seen, got.out_y, exp.out_y));
      if (got.out_w !== exp.out_w)
        report($sformatf("result %0d w got %0d want %0d", results_seen, got.out_w, exp.out_w));
      if (got.out_h !== exp.out_h)
        report($sformatf("result %0d h got %0d want %0d", results_seen, got.out_h, exp.out_h));
      if (got.last !== exp.last)
        report($sformatf("result %0d last got %0b want %0b", results_seen, got.last,
                         exp.last));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b1;
  rsp_t             rsp;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = CFG_SCREEN_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  damage_scoreboard sb = new;
  bit               steady = 1'b0;
  int               cycle_cnt = 0;

  dirty_rect_list i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always #2 clk = ~clk;

  // cycle count for the watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // receiver stalls at random unless in the steady stretch
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // monitor both channels
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready)
      sb.note_request(req);
    if (!rst && rsp_valid && rsp_ready)
      sb.check_result(rsp);
  end

  function automatic req_t rect_cmd(mode_t m, int l, int t, int w, int h);
    req_t item;
    item.mode        = m;
    item.rect_left   = l[POS_W-1:0];
    item.rect_top    = t[POS_W-1:0];
    item.rect_width  = w[DIM_W-1:0];
    item.rect_height = h[DIM_W-1:0];
    return item;
  endfunction

  // random command, mostly adds shaped around the current screen
  function automatic req_t rand_request(int sw, int sh);
    req_t        item;
    logic [31:0] rnd_a, rnd_b;
    int          pick, gx, gy, lf, tp, wd, ht;
    rnd_a = $urandom();
    rnd_b = $urandom();
    item.rect_left   = rnd_a[15:0];
    item.rect_top    = rnd_a[31:16];
    item.rect_width  = rnd_b[14:0];
    item.rect_height = rnd_b[29:15];
    pick = $urandom_range(0, 99);
    if (pick < 9)
      item.mode = MODE_FLUSH;
    else if (pick < 12)
      item.mode = MODE_FULL;
    else if (pick < 14)
      item.mode = MODE_NONE;
    else
      item.mode = MODE_ADD;
    if (item.mode != MODE_ADD)
      return item;
    gx   = (sw < 8) ? 1 : sw / 8;
    gy   = (sh < 8) ? 1 : sh / 8;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // coarse grid so that nesting between entries is common
      lf = gx * $urandom_range(0, 7);
      tp = gy * $urandom_range(0, 7);
      wd = gx * $urandom_range(0, 8);
      ht = gy * $urandom_range(0, 8);
    end else if (pick < 75) begin
      // anywhere near the screen, partly off its top left
      lf = $urandom_range(0, sw + 64) - 64;
      tp = $urandom_range(0, sh + 64) - 64;
      wd = $urandom_range(0, sw / 2 + 64);
      ht = $urandom_range(0, sh / 2 + 64);
    end else if (pick < 90) begin
      // edges exactly on or just past the screen borders
      wd = $urandom_range(0, 40);
      ht = $urandom_range(0, 40);
      lf = $urandom_range(0, sw);
      tp = $urandom_range(0, sh);
      case ($urandom_range(0, 4))
        0:       lf = -wd;
        1:       tp = -ht;
        2:       lf = -wd - 1;
        3:       lf = sw - $urandom_range(0, 1);
        default: tp = sh - $urandom_range(0, 1);
      endcase
    end else begin
      return item;
    end
    return rect_cmd(MODE_ADD, lf, tp, wd, ht);
  endfunction

  // present one request transaction and wait for its acceptance
  task automatic send_item(input req_t item);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // hold off the sender until every expected result has come back
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // write both screen registers while the block is idle
  task automatic write_screen(input int w, input int h);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_screen(w, h);
  endtask

  // watchdog
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // main sequence
  initial begin
    int w, h;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed opening on a 640 x 480 screen
    write_screen(640, 480);
    send_item(rect_cmd(MODE_FLUSH, -1, -1, 32767, 32767));
    send_item(rect_cmd(MODE_NONE, 5, 5, 5, 5));
    send_item(rect_cmd(MODE_ADD, 32767, 32767, 32767, 32767));
    send_item(rect_cmd(MODE_ADD, -32768, -32768, 0, 0));
    // zero width: right edge exactly on zero, kept
    send_item(rect_cmd(MODE_ADD, -10, 5, 10, 5));
    // swallows the zero-width entry
    send_item(rect_cmd(MODE_ADD, 0, 0, 100, 100));
    send_item(rect_cmd(MODE_ADD, 10, 10, 20, 20));
    // fill the list with disjoint boxes, the last one on the far corner
    for (int i = 0; i < 14; i++)
      send_item(rect_cmd(MODE_ADD, 100 + 30 * i, 200, 20, 20));
    send_item(rect_cmd(MODE_ADD, 639, 479, 5, 5));
    // list full, dropped
    send_item(rect_cmd(MODE_ADD, 0, 300, 10, 10));
    send_item(rect_cmd(MODE_FLUSH, 0, 0, 0, 0));
    send_item(rect_cmd(MODE_FULL, 123, -45, 6, 7));
    // huge box clips to the whole screen
    send_item(rect_cmd(MODE_ADD, -20000, -20000, 32767, 32767));

    // random phases over a range of screen sizes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       begin w = 640;  h = 480;  end
        1:       begin w = 4096; h = 4096; end
        2:       begin w = 8191; h = 8191; end
        3:       begin w = 0;    h = 0;    end
        4:       begin w = 1;    h = 4096; end
        5:       begin w = 4097; h = 300;  end
        6:       begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
        default: begin w = 320;  h = 200;  end
      endcase
      write_screen(w, h);
      steady = (ph == 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 3)
          drain_results();
        send_item(rand_request(sb.scr_w, sb.scr_h));
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d results never arrived", sb.outstanding()));
    if (sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
hdl/drl_pkg.sv
hdl/drl_table.sv
hdl/drl_clip.sv
hdl/dirty_rect_list.sv
dv/tb_dirty_rect_list.sv
